[rtl/lcom_pkg.sv]
`timescale 1ns / 1ps

package lcom_pkg;

  localparam int RANGE_W   = 20;
  localparam int COL_W     = 12;
  localparam int IDX_W     = 16;
  localparam int CURV_W    = 47;
  localparam int GAP_W     = 16;
  localparam int DIV_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Window geometry: five neighbours each side plus one point of look-ahead
  localparam int HALF_W     = 5;
  localparam int WIN        = 2 * HALF_W + 2;
  localparam int POS_W      = $clog2(WIN);
  localparam int CURV_START = 2 * HALF_W;
  localparam int OCC_START  = 2 * HALF_W + 1;
  localparam int OCC_POS    = HALF_W + 1;

  // |sum of ten ranges - 10 * centre| fits in 24 bits
  localparam int ASUM_W = RANGE_W + 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OCC_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_DIV = 2'd2;

  localparam logic [GAP_W-1:0] OCC_GAP_RST = 16'd300;
  localparam logic [COL_W-1:0] COL_GAP_RST = 12'd10;
  localparam logic [DIV_W-1:0] PAR_DIV_RST = 8'd50;

  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ASUM_W-1:0]  asum_t;
  typedef logic [CURV_W-1:0]  curv_t;

  typedef logic [WIN-1:0][RANGE_W-1:0] range_win_t;
  typedef logic [WIN-1:0][COL_W-1:0]   col_win_t;
  typedef logic [WIN-1:0][ASUM_W-1:0]  asum_win_t;
  typedef logic [WIN-1:0][IDX_W-1:0]   idx_win_t;

  typedef struct packed {
    logic [GAP_W-1:0] occ_gap;
    logic [COL_W-1:0] col_gap;
    logic [DIV_W-1:0] par_div;
  } cfg_t;

endpackage

[rtl/lcom_ifs.sv]
`timescale 1ns / 1ps

interface lcom_in_if import lcom_pkg::*; ();
  logic   valid;
  logic   ready;
  range_t range_mm;
  col_t   column;
  logic   last_in_scan;

  modport source (output valid, output range_mm, output column, output last_in_scan,
                  input ready);
  modport sink   (input valid, input range_mm, input column, input last_in_scan,
                  output ready);
endinterface

interface lcom_out_if import lcom_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  point_index;
  curv_t curvature;
  logic  curvature_valid;
  logic  picked;
  logic  last_result;

  modport source (output valid, output point_index, output curvature,
                  output curvature_valid, output picked, output last_result,
                  input ready);
  modport sink   (input valid, input point_index, input curvature,
                  input curvature_valid, input picked, input last_result,
                  output ready);
endinterface

interface lcom_cfg_if import lcom_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/lcom_point_eval.sv]
`timescale 1ns / 1ps

// Works on the window after the new point is shifted in (position 0 newest).
// Curvature centre sits at HALF_W; occlusion pair is (OCC_POS, HALF_W).
module lcom_point_eval import lcom_pkg::*; (
  input  range_win_t     rng,
  input  col_win_t       col,
  input  logic           occ_en,
  input  cfg_t           cfg,
  output logic [WIN-1:0] mark,
  output asum_t          asum
);

  asum_t                sum10;
  asum_t                ten_c;
  range_t               ri, rn, rp;
  col_t                 cdiff;
  logic                 near;
  logic [RANGE_W:0]     gap_x;
  logic [RANGE_W:0]     drop;
  logic [RANGE_W:0]     rise;
  range_t               dp, dn;
  logic [RANGE_W+DIV_W-1:0] pp, pn;
  logic                 occ_back, occ_fwd, par;

  always_comb begin
    sum10 = '0;
    for (int j = 0; j <= 2 * HALF_W; j++) begin
      if (j != HALF_W) sum10 = sum10 + ASUM_W'(rng[j]);
    end
    ten_c = (ASUM_W'(rng[HALF_W]) << 3) + (ASUM_W'(rng[HALF_W]) << 1);
    asum  = (sum10 >= ten_c) ? sum10 - ten_c : ten_c - sum10;
  end

  always_comb begin
    ri    = rng[OCC_POS];
    rn    = rng[OCC_POS-1];
    rp    = rng[OCC_POS+1];
    cdiff = (col[OCC_POS] > col[OCC_POS-1]) ? col[OCC_POS] - col[OCC_POS-1]
                                             : col[OCC_POS-1] - col[OCC_POS];
    near  = cdiff < cfg.col_gap;
    gap_x = (RANGE_W+1)'(cfg.occ_gap);
    drop  = {1'b0, ri} - {1'b0, rn};
    rise  = {1'b0, rn} - {1'b0, ri};
    occ_back = near && (ri > rn) && (drop > gap_x);
    occ_fwd  = near && !(ri > rn) && (rn > ri) && (rise > gap_x);

    dp  = (rp > ri) ? rp - ri : ri - rp;
    dn  = (rn > ri) ? rn - ri : ri - rn;
    pp  = dp * cfg.par_div;
    pn  = dn * cfg.par_div;
    par = (pp > (RANGE_W+DIV_W)'(ri)) && (pn > (RANGE_W+DIV_W)'(ri));

    mark = '0;
    if (occ_en) begin
      for (int j = 0; j < WIN; j++) begin
        if (occ_back && j >= OCC_POS) mark[j] = 1'b1;
        if (occ_fwd && j < OCC_POS)   mark[j] = 1'b1;
      end
      if (par) mark[OCC_POS] = 1'b1;
    end
  end

endmodule

[rtl/lidar_curvature_occlusion_marker.sv]
`timescale 1ns / 1ps
// A result reaches out_ch through output stages s1 and out after the transfer that completes it.
// Throughput: one point per cycle unless a flush or an output stall holds input off; point p
// leaves when point p+11 is taken. The last point of a scan releases up to 12 results, one per
// cycle through the two output stages unless out_ch stalls; input is held off while they drain.
// Reset (rst_n low, synchronous): point count, flush and stage valids clear,
// registers return to occlusion_gap 300, column_gap 10, parallel_divisor 50.
module lidar_curvature_occlusion_marker import lcom_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input logic        clk,
  input logic        rst_n,
  lcom_in_if.sink    in_ch,
  lcom_out_if.source out_ch,
  lcom_cfg_if.sink   cfg_ch
);

  localparam int CNT_W = $clog2(MAX_POINTS);

  // ---------------------------------------------------------------- config
  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.occ_gap <= OCC_GAP_RST;
      cfg_r.col_gap <= COL_GAP_RST;
      cfg_r.par_div <= PAR_DIV_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_OCC_GAP: cfg_r.occ_gap <= cfg_ch.data;
        REG_COL_GAP: cfg_r.col_gap <= cfg_ch.data[COL_W-1:0];
        REG_PAR_DIV: cfg_r.par_div <= cfg_ch.data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- window
  // Shift line of the last WIN points, position 0 newest. Each entry keeps its
  // index, picked flag and, once it has reached the centre, its absolute sum.
  logic [CNT_W-1:0] cnt_r;
  logic             flush_r;
  logic [POS_W-1:0] fpos_r;
  range_win_t       rng_r;
  col_win_t         col_r;
  idx_win_t         idx_r;
  asum_win_t        asum_r;
  logic [WIN-1:0]   pck_r;
  logic [WIN-1:0]   cvd_r;

  // Output stage 1 holds the absolute sum, stage 2 the squared curvature
  logic  s1_vld_r;
  idx_t  s1_idx_r;
  asum_t s1_asum_r;
  logic  s1_cv_r;
  logic  s1_pck_r;
  logic  s1_last_r;

  logic  out_vld_r;
  idx_t  out_idx_r;
  curv_t out_curv_r;
  logic  out_cv_r;
  logic  out_pck_r;
  logic  out_last_r;

  logic s2_adv, s1_free, acc, last_acc, curv_en, occ_en;

  assign s2_adv  = !out_vld_r || out_ch.ready;
  assign s1_free = !s1_vld_r || s2_adv;
  assign in_ch.ready = !flush_r && s1_free;
  assign acc      = in_ch.valid && in_ch.ready;
  assign last_acc = in_ch.last_in_scan || (cnt_r == CNT_W'(MAX_POINTS - 1));
  assign curv_en  = cnt_r >= CNT_W'(CURV_START);
  assign occ_en   = cnt_r >= CNT_W'(OCC_START);

  // Window as it stands once the incoming point is in and the marks are laid
  range_win_t     rng_nxt;
  col_win_t       col_nxt;
  idx_win_t       idx_nxt;
  asum_win_t      asum_nxt;
  logic [WIN-1:0] pck_nxt;
  logic [WIN-1:0] cvd_nxt;
  logic [WIN-1:0] mark;
  asum_t          asum_new;

  always_comb begin
    rng_nxt = {rng_r[WIN-2:0], in_ch.range_mm};
    col_nxt = {col_r[WIN-2:0], in_ch.column};
    idx_nxt = {idx_r[WIN-2:0], IDX_W'(cnt_r)};
  end

  lcom_point_eval u_eval (
    .rng    (rng_nxt),
    .col    (col_nxt),
    .occ_en (occ_en),
    .cfg    (cfg_r),
    .mark   (mark),
    .asum   (asum_new)
  );

  always_comb begin
    asum_nxt = {asum_r[WIN-2:0], ASUM_W'(0)};
    cvd_nxt  = {cvd_r[WIN-2:0], 1'b0};
    if (curv_en) begin
      asum_nxt[HALF_W] = asum_new;
      cvd_nxt[HALF_W]  = 1'b1;
    end
    // the new point starts unpicked; the marks may still set it
    pck_nxt = {pck_r[WIN-2:0], 1'b0} | mark;
  end

  // ---------------------------------------------------------------- emit
  // On a plain transfer with the window full the oldest entry leaves; on the last point every
  // held entry drains oldest first, the first result in the same cycle.
  logic             emit;
  logic [POS_W-1:0] em_pos;
  logic             em_last;
  idx_t             em_idx;
  asum_t            em_asum;
  logic             em_cv;
  logic             em_pck;

  always_comb begin
    emit    = 1'b0;
    em_pos  = POS_W'(WIN - 1);
    em_last = 1'b0;
    if (flush_r) begin
      emit    = s1_free;
      em_pos  = fpos_r;
      em_last = (fpos_r == '0);
    end else if (acc) begin
      if (last_acc) begin
        emit    = 1'b1;
        em_pos  = occ_en ? POS_W'(WIN - 1) : cnt_r[POS_W-1:0];
        em_last = (em_pos == '0);
      end else begin
        emit = occ_en;
      end
    end
    if (flush_r) begin
      em_idx  = idx_r[em_pos];
      em_asum = asum_r[em_pos];
      em_cv   = cvd_r[em_pos];
      em_pck  = pck_r[em_pos];
    end else begin
      em_idx  = idx_nxt[em_pos];
      em_asum = asum_nxt[em_pos];
      em_cv   = cvd_nxt[em_pos];
      em_pck  = pck_nxt[em_pos];
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flush_r <= 1'b0;
      fpos_r  <= '0;
    end else if (flush_r) begin
      if (s1_free) begin
        if (fpos_r == '0) flush_r <= 1'b0;
        else fpos_r <= fpos_r - 1'b1;
      end
    end else if (acc) begin
      cnt_r <= last_acc ? '0 : cnt_r + 1'b1;
      if (last_acc && em_pos != '0) begin
        flush_r <= 1'b1;
        fpos_r  <= em_pos - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rng_r  <= rng_nxt;
      col_r  <= col_nxt;
      idx_r  <= idx_nxt;
      asum_r <= asum_nxt;
      pck_r  <= pck_nxt;
      cvd_r  <= cvd_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_free) s1_vld_r <= emit;
      if (s2_adv) out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && emit) begin
      s1_idx_r  <= em_idx;
      s1_asum_r <= em_asum;
      s1_cv_r   <= em_cv;
      s1_pck_r  <= em_pck;
      s1_last_r <= em_last;
    end
    if (s2_adv && s1_vld_r) begin
      out_idx_r  <= s1_idx_r;
      out_curv_r <= s1_cv_r ? CURV_W'(s1_asum_r * s1_asum_r) : '0;
      out_cv_r   <= s1_cv_r;
      out_pck_r  <= s1_pck_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.point_index     = out_idx_r;
  assign out_ch.curvature       = out_curv_r;
  assign out_ch.curvature_valid = out_cv_r;
  assign out_ch.picked          = out_pck_r;
  assign out_ch.last_result     = out_last_r;

  // ---------------------------------------------------------------- checks
  // no new point may enter while the window drains
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> !in_ch.ready)
    else $error("input taken during flush");

  // the point count restarts after the last point of a scan
  a_count_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_acc |=> cnt_r == '0)
    else $error("point count not cleared after last point");

  // an edge point never carries a curvature
  a_edge_curv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_cv_r |-> out_curv_r == '0)
    else $error("curvature on an edge point");

  // the final flush step ends the flush
  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r && fpos_r == '0 && s1_free |=> !flush_r)
    else $error("flush did not end");

endmodule

[test/curvature_mark_checker.sv]
`timescale 1ns / 1ps

// Watches the point, result and register channels; keeps a private model of the
// window and thresholds, queues the results each point transfer must produce
// and checks every result transfer against the oldest one queued.
module curvature_mark_checker import lcom_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  logic clk,
  input  logic rst_n,
  lcom_in_if   in_mon,
  lcom_out_if  out_mon,
  lcom_cfg_if  cfg_mon,
  output int   pending,
  output int   fail_count
);

  localparam int CDEPTH = HALF_W + 1;

  typedef struct packed {
    idx_t  point_index;
    curv_t curvature;
    logic  curvature_valid;
    logic  picked;
    logic  last_result;
  } point_result_t;

  logic [GAP_W-1:0] occ_gap;
  col_t             col_gap;
  logic [DIV_W-1:0] par_div;

  range_t      range_hist [WIN];
  col_t        col_hist   [WIN];
  logic        pick_hist  [WIN];
  curv_t       curv_hist  [CDEPTH];
  int unsigned next_index;

  point_result_t expected_points [$];
  int            mismatches = 0;

  function automatic longint unsigned span(input longint unsigned a, input longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic clear_window();
    for (int j = 0; j < WIN; j++) begin
      range_hist[j] = '0;
      col_hist[j]   = '0;
      pick_hist[j]  = 1'b0;
    end
    for (int j = 0; j < CDEPTH; j++) curv_hist[j] = '0;
    next_index = 0;
  endtask

  task automatic note_mismatch(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    $error("%s: expected %0d, got %0d", name, want, got);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) note_mismatch(name, want, got);
  endtask

  // One point in: update the window, mark occlusions and grazing beams, and
  // queue the point that leaves (or the whole tail on the scan's last point).
  task automatic predict_point(input range_t r, input col_t c, input logic end_flag);
    int unsigned       k, ctr, i, first, stop;
    logic              closes, have_fresh;
    longint            acc;
    longint unsigned   mag;
    curv_t             fresh;
    range_t            ri, rn, rp;
    point_result_t     res;
    k      = next_index;
    closes = end_flag || (k >= MAX_POINTS - 1);
    range_hist[k % WIN] = r;
    col_hist[k % WIN]   = c;
    pick_hist[k % WIN]  = 1'b0;
    fresh      = '0;
    have_fresh = 1'b0;

    if (k >= CURV_START) begin
      ctr = k - HALF_W;
      acc = -longint'(2 * HALF_W) * longint'(range_hist[ctr % WIN]);
      for (int d = 1; d <= HALF_W; d++)
        acc += longint'(range_hist[(ctr - d) % WIN]) + longint'(range_hist[(ctr + d) % WIN]);
      mag        = (acc < 0) ? -acc : acc;
      fresh      = curv_t'(mag * mag);
      have_fresh = 1'b1;
    end

    if (k >= OCC_START) begin
      i  = k - OCC_POS;
      ri = range_hist[i % WIN];
      rn = range_hist[(i + 1) % WIN];
      rp = range_hist[(i - 1) % WIN];
      if (span(col_hist[(i + 1) % WIN], col_hist[i % WIN]) < col_gap) begin
        if (ri > rn && ri - rn > occ_gap) begin
          for (int d = 0; d <= HALF_W; d++) pick_hist[(i - d) % WIN] = 1'b1;
        end else if (rn > ri && rn - ri > occ_gap) begin
          for (int d = 1; d <= HALF_W + 1; d++) pick_hist[(i + d) % WIN] = 1'b1;
        end
      end
      if (span(rp, ri) * par_div > ri && span(rn, ri) * par_div > ri)
        pick_hist[i % WIN] = 1'b1;
    end

    first = (k >= OCC_START) ? k - OCC_START : 0;
    if (closes || k >= OCC_START) begin
      stop = closes ? k : first;
      for (int unsigned p = first; p <= stop; p++) begin
        res.point_index     = idx_t'(p);
        res.curvature_valid = (p >= HALF_W) && (p + HALF_W <= k);
        if (!res.curvature_valid)   res.curvature = '0;
        else if (p + HALF_W == k)   res.curvature = fresh;
        else                        res.curvature = curv_hist[p % CDEPTH];
        res.picked      = pick_hist[p % WIN];
        res.last_result = closes && (p == k);
        expected_points.insert(expected_points.size(), res);
      end
    end

    if (have_fresh) curv_hist[(k - HALF_W) % CDEPTH] = fresh;
    next_index = closes ? 0 : k + 1;
  endtask

  always @(posedge clk) begin
    point_result_t want;
    if (!rst_n) begin
      occ_gap = OCC_GAP_RST;
      col_gap = COL_GAP_RST;
      par_div = PAR_DIV_RST;
      clear_window();
      expected_points.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_OCC_GAP: occ_gap = cfg_mon.data;
          REG_COL_GAP: col_gap = cfg_mon.data[COL_W-1:0];
          REG_PAR_DIV: par_div = cfg_mon.data[DIV_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_point(in_mon.range_mm, in_mon.column, in_mon.last_in_scan);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_points.size() == 0) begin
          note_mismatch("unexpected result point_index", '0, 64'(out_mon.point_index));
        end else begin
          want = expected_points.pop_front();
          check_field("point_index", 64'(want.point_index), 64'(out_mon.point_index));
          check_field("curvature", 64'(want.curvature), 64'(out_mon.curvature));
          check_field("curvature_valid", 64'(want.curvature_valid),
                      64'(out_mon.curvature_valid));
          check_field("picked", 64'(want.picked), 64'(out_mon.picked));
          check_field("last_result", 64'(want.last_result), 64'(out_mon.last_result));
        end
      end
    end
    pending    <= expected_points.size();
    fail_count <= mismatches;
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lcom_pkg::*;

  localparam int FULL_SCAN       = 65536;  // forced end of scan at this many points
  localparam int RANDOM_POINTS   = 320;
  localparam int HOLD_OFF_CYCLES = 80;     // long receiver stall, fills the pipe
  localparam int SETTLE_CYCLES   = 4;      // quiet time before a register write
  localparam int TAIL_CYCLES     = 20;

  // spare register slot, the block should ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // hand-picked scan: occlusion step up, step down, a grazing-beam spike,
  // a full-scale range and a column break
  localparam int unsigned EDGE_RANGES [20] = '{
    2000, 2000, 2000, 2000, 2000, 2000, 2000, 5000, 5000, 5000,
    1000, 1000, 1000, 1100, 1000, 1000, 1048575, 1000, 0, 0
  };

  logic clk;
  logic rst_n;

  lcom_in_if  in_ch ();
  lcom_out_if out_ch ();
  lcom_cfg_if cfg_ch ();

  int pending;
  int fail_count;

  bit idle_on;         // random bursts of idling on both channels
  int hold_asks   = 0; // bumped by the stimulus, served by the sink pacing
  int hold_served = 0;
  int points_sent = 0;

  lidar_curvature_occlusion_marker #(
    .MAX_POINTS(FULL_SCAN)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  curvature_mark_checker #(
    .MAX_POINTS(FULL_SCAN)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one point and hold it until the transfer. valid is left high on
  // return so back-to-back points go without a bubble.
  task automatic send_point(input range_t r, input col_t c, input logic end_flag);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.range_mm     <= r;
    in_ch.column       <= c;
    in_ch.last_in_scan <= end_flag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    points_sent++;
  endtask

  // Stop offering and wait for every queued result to come out.
  // The first edge lets the checker see the final point transfer.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Only written with the block idle and between scans. The spare slot gets
  // a random write each time; it must not disturb anything.
  task automatic set_thresholds(input logic [CFG_DAT_W-1:0] occ,
                                input logic [CFG_DAT_W-1:0] colv,
                                input logic [CFG_DAT_W-1:0] divv);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DAT_W-1:0] val [4];
    idx = '{REG_OCC_GAP, REG_COL_GAP, REG_PAR_DIV, REG_SPARE};
    val = '{occ, colv, divv, CFG_DAT_W'($urandom)};
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int j = 0; j < 4; j++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[j];
      cfg_ch.data  <= val[j];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // One scan. A tidy scan is a smooth surface with jitter, the odd range
  // jump (occlusion edges) and mostly consecutive columns with the odd break;
  // otherwise every field is noise. pause_at stops mid-scan until drained.
  task automatic run_scan(input int len, input bit tidy, input bit mark_end,
                          input int pause_at);
    int     level;
    int     sample;
    col_t   col;
    range_t r;
    col_t   c;
    level = $urandom_range(300, 80000);
    col   = col_t'($urandom);
    for (int k = 0; k < len; k++) begin
      if (k == pause_at) drain();
      if (tidy) begin
        case ($urandom_range(0, 15))
          0:       level = $urandom_range(0, 1048575);
          1:       level = $urandom_range(200, 20000);
          default: ;
        endcase
        sample = level + $urandom_range(0, 64) - 32;
        if (sample < 0)       sample = 0;
        if (sample > 1048575) sample = 1048575;
        r = range_t'(sample);
        c = ($urandom_range(0, 19) == 0) ? col_t'($urandom) : col + 1'b1;
        col = c;
      end else begin
        r = range_t'($urandom);
        c = col_t'($urandom);
      end
      send_point(r, c, mark_end && (k == len - 1));
    end
  endtask

  // Sink pacing: ready high, random stall bursts while idling is on, and the
  // long hold-off when asked for, counted here in cycles.
  initial begin : sink_pacing
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_asks != hold_served) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_served++;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int scans;
    int len;
    in_ch.valid        <= 1'b0;
    in_ch.range_mm     <= '0;
    in_ch.column       <= '0;
    in_ch.last_in_scan <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_OCC_GAP;
    cfg_ch.data        <= '0;
    rst_n              <= 1'b0;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, on reset thresholds. One-point scan at full scale.
    send_point(20'hFFFFF, 12'hFFF, 1'b1);
    // Short scan, never fills the window: every point is an edge point.
    send_point(20'h00000, 12'h000, 1'b0);
    send_point(20'hFFFFF, 12'h001, 1'b0);
    send_point(20'h00000, 12'h002, 1'b0);
    send_point(20'd1000,  12'h003, 1'b1);
    // Occlusion and grazing-beam scan.
    for (int k = 0; k < 20; k++)
      send_point(range_t'(EDGE_RANGES[k]), (k == 17) ? 12'hFFF : col_t'(100 + k), k == 19);

    // Rewrite the reset thresholds, spare slot included.
    set_thresholds(16'd300, 16'd10, 16'd50);

    // Random scans, thresholds changed every third scan, extremes included.
    // The upper data bits are set at times; only the register's width counts.
    points_sent = 0;
    scans       = 0;
    while (points_sent < RANDOM_POINTS) begin
      if (points_sent >= RANDOM_POINTS * 2 / 3) idle_on = 1'b0;
      if (scans % 3 == 2) begin
        case ($urandom_range(0, 5))
          0: set_thresholds(16'd0, 16'hF000, 16'hFF00);       // gaps zero, divisor zero
          1: set_thresholds(16'hFFFF, 16'h0FFF, 16'h00FF);    // all at maximum
          2: set_thresholds(16'd0, 16'h0FFF, 16'd1);
          3: set_thresholds(16'hFFFF, 16'd0, 16'd255);
          default: set_thresholds(CFG_DAT_W'($urandom_range(0, 2000)),
                                  {4'($urandom), 12'($urandom_range(0, 40))},
                                  CFG_DAT_W'($urandom));
        endcase
      end
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 11);
        1:       len = $urandom_range(11, 13);
        2:       len = $urandom_range(60, 80);
        default: len = $urandom_range(12, 40);
      endcase
      if (scans == 0) begin
        // long receiver hold-off while points keep coming: input must stall
        hold_asks++;
        run_scan(45, 1'b1, 1'b1, -1);
      end else if (scans == 1) begin
        // sender waits mid-scan for every result to come out
        run_scan(30, 1'b1, 1'b1, 15);
      end else begin
        run_scan(len, $urandom_range(0, 4) != 0, 1'b1, -1);
      end
      scans++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[files.f]
rtl/lcom_pkg.sv
rtl/lcom_ifs.sv
rtl/lcom_point_eval.sv
rtl/lidar_curvature_occlusion_marker.sv
test/curvature_mark_checker.sv
test/tb_top.sv
